// ===== design/utld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC to local date/time: shared types and constants
// Calendar constants, the time-of-day bundle and small lookup functions used
// by the day-count front end and the civil-date back end.
// ----------------------------------------------------------------------------
package utld_pkg;

    localparam logic [17:0] DaysPerEra     = 18'd146097;
    localparam logic [17:0] DaysPerCentury = 18'd36524;
    localparam logic [17:0] DaysPer4Years  = 18'd1460;
    localparam logic [17:0] DaysPerYear    = 18'd365;
    localparam logic [8:0]  YearsPerEra    = 9'd400;
    localparam logic [10:0] MinPerDay      = 11'd1440;
    localparam logic [10:0] MinPerHour     = 11'd60;
    localparam logic [5:0]  SecPerMin      = 6'd60;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // Day of the March-based year on which month index idx starts
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Whole centuries in a year of era (0..399)
    function automatic logic [1:0] cent_of(input logic [8:0] yoe);
        logic [1:0] v;
        priority if (yoe >= 9'd300) begin
            v = 2'd3;
        end else if (yoe >= 9'd200) begin
            v = 2'd2;
        end else if (yoe >= 9'd100) begin
            v = 2'd1;
        end else begin
            v = 2'd0;
        end
        return v;
    endfunction

endpackage

// ===== design/utld_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC to local date/time: day-count front end
// Five-stage pipeline: maps the UTC date to a day count within the era
// system, applies the offset to the minute of day, splits off the day carry
// and forms a non-negative shifted day number plus the local time of day.
// ----------------------------------------------------------------------------
module utld_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [13:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic [5:0]         i_second,
    input  logic signed [10:0] i_tz_offset,
    output logic               o_valid,
    output logic [22:0]        o_days,
    output utld_pkg::t_tod     o_tod
);
    import utld_pkg::*;

    // floor(2^15 / 400): quotient low by at most one
    localparam logic [21:0] RecipEra  = 22'd81;
    // ceil(2^18 / 60): exact for minutes of a day
    localparam logic [23:0] RecipHour = 24'd4370;

    logic               r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;

    logic               jan_feb;
    logic [3:0]         mi;
    logic               sec_carry;
    logic [10:0]        hm;
    logic [14:0]        n_s1_x;
    logic signed [9:0]  n_s1_doy;
    logic signed [12:0] n_s1_min;
    logic [5:0]         n_s1_sec;
    logic [14:0]        r_s1_x;
    logic signed [9:0]  r_s1_doy;
    logic signed [12:0] r_s1_min;
    logic [5:0]         r_s1_sec;

    logic [21:0]        era_prod;
    logic [5:0]         n_s2_q0;
    logic signed [2:0]  n_s2_c;
    logic [10:0]        n_s2_mrem;
    logic [5:0]         r_s2_q0;
    logic [14:0]        r_s2_x;
    logic signed [9:0]  r_s2_doy;
    logic signed [2:0]  r_s2_c;
    logic [10:0]        r_s2_mrem;
    logic [5:0]         r_s2_sec;

    logic [14:0]        era_rem;
    logic [23:0]        hour_prod;
    logic [8:0]         n_s3_yoe;
    logic [5:0]         n_s3_e;
    logic [8:0]         r_s3_yoe;
    logic [5:0]         r_s3_e;
    logic signed [9:0]  r_s3_doy;
    logic signed [2:0]  r_s3_c;
    logic [4:0]         r_s3_hour;
    logic [10:0]        r_s3_mrem;
    logic [5:0]         r_s3_sec;

    logic [17:0]        doe_u;
    logic [10:0]        min_rem;
    logic signed [18:0] n_s4_doe;
    logic signed [18:0] r_s4_doe;
    logic [5:0]         r_s4_e;
    logic signed [2:0]  r_s4_c;
    t_tod               n_s4_tod;
    t_tod               r_s4_tod;

    logic [22:0]        era_base;
    logic signed [23:0] n_s5_sum;
    logic [22:0]        r_s5_days;
    t_tod               r_s5_tod;

    // Stage 1: March-based year shift, day of year, minute of day plus offset
    always_comb begin
        jan_feb   = (i_month <= 4'd2);
        mi        = jan_feb ? i_month + 4'd9 : i_month - 4'd3;
        n_s1_x    = {1'b0, i_year} + 15'({YearsPerEra}) - {14'd0, jan_feb};
        n_s1_doy  = $signed({1'b0, month_start(mi)} + {5'd0, i_day} - 10'd1);
        sec_carry = (i_second >= SecPerMin);
        n_s1_sec  = sec_carry ? i_second - SecPerMin : i_second;
        hm        = {6'd0, i_hour} * MinPerHour + {5'd0, i_minute} + {10'd0, sec_carry};
        n_s1_min  = $signed({2'b00, hm}) + 13'(i_tz_offset);
    end

    // Stage 2: era estimate, day carry from the minute of day
    always_comb begin
        era_prod = 22'(r_s1_x) * RecipEra;
        n_s2_q0  = era_prod[20:15];
        priority if (r_s1_min < 13'sd0) begin
            n_s2_c    = -3'sd1;
            n_s2_mrem = 11'(r_s1_min + 13'sd1440);
        end else if (r_s1_min >= 13'sd2880) begin
            n_s2_c    = 3'sd2;
            n_s2_mrem = 11'(r_s1_min - 13'sd2880);
        end else if (r_s1_min >= 13'sd1440) begin
            n_s2_c    = 3'sd1;
            n_s2_mrem = 11'(r_s1_min - 13'sd1440);
        end else begin
            n_s2_c    = 3'sd0;
            n_s2_mrem = 11'(r_s1_min);
        end
    end

    // Stage 3: correct era quotient, hour of day
    always_comb begin
        era_rem = r_s2_x - {9'd0, r_s2_q0} * 15'({YearsPerEra});
        if (era_rem >= 15'({YearsPerEra})) begin
            n_s3_yoe = 9'(era_rem - 15'({YearsPerEra}));
            n_s3_e   = r_s2_q0 + 6'd1;
        end else begin
            n_s3_yoe = era_rem[8:0];
            n_s3_e   = r_s2_q0;
        end
        hour_prod = 24'(r_s2_mrem) * RecipHour;
    end

    // Stage 4: day of era, minute of hour
    always_comb begin
        doe_u    = {9'd0, r_s3_yoe} * DaysPerYear + {11'd0, r_s3_yoe[8:2]}
                   - {16'd0, cent_of(r_s3_yoe)};
        n_s4_doe = $signed({1'b0, doe_u}) + 19'(r_s3_doy);
        min_rem  = r_s3_mrem - {6'd0, r_s3_hour} * MinPerHour;
        n_s4_tod.hour   = r_s3_hour;
        n_s4_tod.minute = min_rem[5:0];
        n_s4_tod.second = r_s3_sec;
    end

    // Stage 5: day number counted from two eras before the year shift base
    always_comb begin
        era_base = ({17'd0, r_s4_e} + 23'd1) * {5'd0, DaysPerEra};
        n_s5_sum = $signed({1'b0, era_base}) + 24'(r_s4_doe) + 24'(r_s4_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x    <= n_s1_x;
        r_s1_doy  <= n_s1_doy;
        r_s1_min  <= n_s1_min;
        r_s1_sec  <= n_s1_sec;

        r_s2_q0   <= n_s2_q0;
        r_s2_x    <= r_s1_x;
        r_s2_doy  <= r_s1_doy;
        r_s2_c    <= n_s2_c;
        r_s2_mrem <= n_s2_mrem;
        r_s2_sec  <= r_s1_sec;

        r_s3_yoe  <= n_s3_yoe;
        r_s3_e    <= n_s3_e;
        r_s3_doy  <= r_s2_doy;
        r_s3_c    <= r_s2_c;
        r_s3_hour <= hour_prod[22:18];
        r_s3_mrem <= r_s2_mrem;
        r_s3_sec  <= r_s2_sec;

        r_s4_doe  <= n_s4_doe;
        r_s4_e    <= r_s3_e;
        r_s4_c    <= r_s3_c;
        r_s4_tod  <= n_s4_tod;

        r_s5_days <= n_s5_sum[22:0];
        r_s5_tod  <= r_s4_tod;
    end

    assign o_valid = r_s5_v;
    assign o_days  = r_s5_days;
    assign o_tod   = r_s5_tod;

`ifndef SYNTHESIS
    a_mrem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> r_s2_mrem < MinPerDay)
        else $error("minute of day out of range after day carry");
    a_yoe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> r_s3_yoe < YearsPerEra)
        else $error("year of era not reduced");
    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> (r_s4_tod.hour < 5'd24 && r_s4_tod.minute < 6'd60
                    && r_s4_tod.second < 6'd60))
        else $error("time of day out of range");
`endif

endmodule

// ===== design/utld_civil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC to local date/time: civil date back end
// Eight-stage pipeline: splits the shifted day number into era and day of
// era, derives year of era, day of year and month, and assembles the local
// date. The time of day travels alongside.
// ----------------------------------------------------------------------------
module utld_civil (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [22:0]    i_days,
    input  utld_pkg::t_tod i_tod,
    output logic           o_valid,
    output logic [13:0]    o_year,
    output logic [3:0]     o_month,
    output logic [4:0]     o_day,
    output utld_pkg::t_tod o_tod
);
    import utld_pkg::*;

    // floor(2^23 / 146097), floor(2^18 / 1460), floor(2^18 / 365):
    // each quotient low by at most one, fixed by one compare
    localparam logic [28:0] RecipDaysEra  = 29'd57;
    localparam logic [25:0] RecipDays4Yr  = 26'd179;
    localparam logic [27:0] RecipDaysYear = 28'd718;

    logic [7:0]  r_v;
    t_tod        r_tod [8];

    logic [28:0] c1_prod;
    logic [5:0]  r_c1_q0;
    logic [22:0] r_c1_x;

    logic [22:0] c2_rem;
    logic [17:0] n_c2_doe;
    logic [5:0]  n_c2_e;
    logic [17:0] r_c2_doe;
    logic [5:0]  r_c2_e;

    logic [25:0] c3_prod;
    logic [1:0]  n_c3_bc;
    logic [6:0]  r_c3_a0;
    logic [1:0]  r_c3_bc;
    logic [17:0] r_c3_doe;
    logic [5:0]  r_c3_e;

    logic [17:0] c4_rem;
    logic [6:0]  c4_a;
    logic [17:0] r_c4_t;
    logic [17:0] r_c4_doe;
    logic [5:0]  r_c4_e;

    logic [27:0] c5_prod;
    logic [8:0]  r_c5_y0;
    logic [17:0] r_c5_t;
    logic [17:0] r_c5_doe;
    logic [5:0]  r_c5_e;

    logic [17:0] c6_rem;
    logic [8:0]  n_c6_yoe;
    logic [8:0]  r_c6_yoe;
    logic [17:0] r_c6_doe;
    logic [5:0]  r_c6_e;

    logic [17:0] c7_full;
    logic [8:0]  r_c7_doy;
    logic [8:0]  r_c7_yoe;
    logic [5:0]  r_c7_e;

    logic [3:0]  mp;
    logic [8:0]  c8_dom;
    logic [3:0]  n_c8_month;
    logic        c8_jf;
    logic [13:0] n_c8_year;
    logic [13:0] r_c8_year;
    logic [3:0]  r_c8_month;
    logic [4:0]  r_c8_day;

    // C1: era estimate
    assign c1_prod = {6'd0, i_days} * RecipDaysEra;

    // C2: correct era, day of era
    always_comb begin
        c2_rem = r_c1_x - {17'd0, r_c1_q0} * {5'd0, DaysPerEra};
        if (c2_rem >= {5'd0, DaysPerEra}) begin
            n_c2_doe = 18'(c2_rem - {5'd0, DaysPerEra});
            n_c2_e   = r_c1_q0 + 6'd1;
        end else begin
            n_c2_doe = c2_rem[17:0];
            n_c2_e   = r_c1_q0;
        end
    end

    // C3: four-year estimate, centuries less the last day of the era
    always_comb begin
        c3_prod = {8'd0, r_c2_doe} * RecipDays4Yr;
        priority if (r_c2_doe >= 18'(DaysPerCentury * 3)) begin
            n_c3_bc = 2'd3;
        end else if (r_c2_doe >= 18'(DaysPerCentury * 2)) begin
            n_c3_bc = 2'd2;
        end else if (r_c2_doe >= DaysPerCentury) begin
            n_c3_bc = 2'd1;
        end else begin
            n_c3_bc = 2'd0;
        end
    end

    // C4: leap-corrected day count
    always_comb begin
        c4_rem = r_c3_doe - {11'd0, r_c3_a0} * DaysPer4Years;
        c4_a   = r_c3_a0 + {6'd0, (c4_rem >= DaysPer4Years)};
    end

    // C5: year estimate
    assign c5_prod = {10'd0, r_c4_t} * RecipDaysYear;

    // C6: correct year of era
    always_comb begin
        c6_rem   = r_c5_t - {9'd0, r_c5_y0} * DaysPerYear;
        n_c6_yoe = r_c5_y0 + {8'd0, (c6_rem >= DaysPerYear)};
    end

    // C7: day of the March-based year
    assign c7_full = r_c6_doe - ({9'd0, r_c6_yoe} * DaysPerYear + {11'd0, r_c6_yoe[8:2]}
                     - {16'd0, cent_of(r_c6_yoe)});

    // C8: month, day and year
    always_comb begin
        mp = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r_c7_doy >= month_start(4'(i))) begin
                mp = 4'(i);
            end
        end
        c8_dom     = r_c7_doy - month_start(mp) + 9'd1;
        c8_jf      = (mp >= 4'd10);
        n_c8_month = c8_jf ? mp - 4'd9 : mp + 4'd3;
        n_c8_year  = {5'd0, r_c7_yoe} + {8'd0, r_c7_e} * 14'({YearsPerEra})
                     - 14'd800 + {13'd0, c8_jf};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tod[0] <= i_tod;
        for (int k = 1; k < 8; k++) begin
            r_tod[k] <= r_tod[k-1];
        end

        r_c1_q0    <= c1_prod[28:23];
        r_c1_x     <= i_days;

        r_c2_doe   <= n_c2_doe;
        r_c2_e     <= n_c2_e;

        r_c3_a0    <= c3_prod[24:18];
        r_c3_bc    <= n_c3_bc;
        r_c3_doe   <= r_c2_doe;
        r_c3_e     <= r_c2_e;

        r_c4_t     <= r_c3_doe - {11'd0, c4_a} + {16'd0, r_c3_bc};
        r_c4_doe   <= r_c3_doe;
        r_c4_e     <= r_c3_e;

        r_c5_y0    <= c5_prod[26:18];
        r_c5_t     <= r_c4_t;
        r_c5_doe   <= r_c4_doe;
        r_c5_e     <= r_c4_e;

        r_c6_yoe   <= n_c6_yoe;
        r_c6_doe   <= r_c5_doe;
        r_c6_e     <= r_c5_e;

        r_c7_doy   <= c7_full[8:0];
        r_c7_yoe   <= r_c6_yoe;
        r_c7_e     <= r_c6_e;

        r_c8_year  <= n_c8_year;
        r_c8_month <= n_c8_month;
        r_c8_day   <= c8_dom[4:0];
    end

    assign o_valid = r_v[7];
    assign o_year  = r_c8_year;
    assign o_month = r_c8_month;
    assign o_day   = r_c8_day;
    assign o_tod   = r_tod[7];

`ifndef SYNTHESIS
    a_doe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> r_c2_doe < DaysPerEra)
        else $error("day of era not reduced");
    a_yoe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] |-> r_c6_yoe < YearsPerEra)
        else $error("year of era out of range");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, 8))
        else $error("result without a matching transfer");
`endif

endmodule

// ===== design/utc_to_local_datetime.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC to local date/time converter
// Converts a UTC calendar date and time to local date and time under a
// configured signed offset in minutes.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the UTC fields and raise start; the item transfers at each
//   rising edge with start high and busy low. busy stays low, so one item
//   may transfer in every cycle.
//   Output: each result is shown for one cycle with o_valid high and
//   transfers at the edge that ends that cycle; the receiver has no stall.
//   Results come out in input order; each passes through the 5-stage
//   day-count front end and then the 8-stage civil-date back end before it
//   is shown on the ports. Throughput is one item per cycle.
//   Configuration: i_cfg_we writes i_cfg_wdata to the offset register;
//   write it only while no item is in flight.
//   Reset: synchronous, active low; clears the pipeline valid bits and sets
//   the offset to zero. Items in flight at reset are dropped.
// ----------------------------------------------------------------------------
module utc_to_local_datetime (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic signed [10:0] i_cfg_wdata,
    input  logic [13:0]        i_utc_year,
    input  logic [3:0]         i_utc_month,
    input  logic [4:0]         i_utc_day,
    input  logic [4:0]         i_utc_hour,
    input  logic [5:0]         i_utc_minute,
    input  logic [5:0]         i_utc_second,
    output logic               o_valid,
    output logic [13:0]        o_local_year,
    output logic [3:0]         o_local_month,
    output logic [4:0]         o_local_day,
    output logic [4:0]         o_local_hour,
    output logic [5:0]         o_local_minute,
    output logic [5:0]         o_local_second
);
    import utld_pkg::*;

    logic signed [10:0] r_tz_offset;
    logic               in_xfer;
    logic               front_valid;
    logic [22:0]        front_days;
    t_tod               front_tod;
    t_tod               local_tod;

    assign busy    = 1'b0;
    assign in_xfer = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz_offset <= '0;
        end else if (i_cfg_we) begin
            r_tz_offset <= i_cfg_wdata;
        end
    end

    utld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_xfer),
        .i_year      (i_utc_year),
        .i_month     (i_utc_month),
        .i_day       (i_utc_day),
        .i_hour      (i_utc_hour),
        .i_minute    (i_utc_minute),
        .i_second    (i_utc_second),
        .i_tz_offset (r_tz_offset),
        .o_valid     (front_valid),
        .o_days      (front_days),
        .o_tod       (front_tod)
    );

    utld_civil u_civil (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_days  (front_days),
        .i_tod   (front_tod),
        .o_valid (o_valid),
        .o_year  (o_local_year),
        .o_month (o_local_month),
        .o_day   (o_local_day),
        .o_tod   (local_tod)
    );

    assign o_local_hour   = local_tod.hour;
    assign o_local_minute = local_tod.minute;
    assign o_local_second = local_tod.second;

endmodule

// ===== sim/tb_utc_to_local_datetime.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UTC to local date/time converter
// Streams UTC timestamps through the converter under a series of time-zone
// offsets and checks every local date/time against a calendar predictor.
// Inputs include edge dates, out-of-range fields and random values, with
// random input idle bursts.
// ----------------------------------------------------------------------------
module tb_utc_to_local_datetime;

    localparam longint EpochShiftDays = 719468;
    localparam longint DaysPerEra     = 146097;
    localparam longint SecPerDay      = 86400;
    localparam int     PipeLatency    = 13;
    localparam int     WatchdogLimit  = 500;
    localparam int     MaxReports     = 10;
    localparam int     PhaseItems     = 180;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_utc_stamp;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_local_stamp;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic signed [10:0] i_cfg_wdata = '0;
    logic [13:0]        i_utc_year = '0;
    logic [3:0]         i_utc_month = '0;
    logic [4:0]         i_utc_day = '0;
    logic [4:0]         i_utc_hour = '0;
    logic [5:0]         i_utc_minute = '0;
    logic [5:0]         i_utc_second = '0;
    logic               o_valid;
    logic [13:0]        o_local_year;
    logic [3:0]         o_local_month;
    logic [4:0]         o_local_day;
    logic [4:0]         o_local_hour;
    logic [5:0]         o_local_minute;
    logic [5:0]         o_local_second;

    t_utc_stamp   pending_utc[$];
    t_local_stamp expected_local[$];
    t_utc_stamp   driven_utc;
    longint       offset_now = 0;
    int           idle_left = 0;
    bit           idle_enable = 1'b1;
    int           n_fail = 0;
    int           n_checked = 0;
    int           n_offsets = 1;
    int           stall_cycles = 0;

    int unsigned year_edges [0:11] = '{0, 1, 399, 400, 1600, 1969, 1970, 2000, 2100,
                                       9999, 10000, 16383};
    int unsigned month_edges [0:5] = '{0, 1, 2, 12, 13, 15};
    int unsigned day_edges [0:5]   = '{0, 1, 28, 29, 30, 31};
    int unsigned hour_edges [0:3]  = '{0, 23, 24, 31};
    int unsigned sixty_edges [0:3] = '{0, 59, 60, 63};

    utc_to_local_datetime DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_utc_year     (i_utc_year),
        .i_utc_month    (i_utc_month),
        .i_utc_day      (i_utc_day),
        .i_utc_hour     (i_utc_hour),
        .i_utc_minute   (i_utc_minute),
        .i_utc_second   (i_utc_second),
        .o_valid        (o_valid),
        .o_local_year   (o_local_year),
        .o_local_month  (o_local_month),
        .o_local_day    (o_local_day),
        .o_local_hour   (o_local_hour),
        .o_local_minute (o_local_minute),
        .o_local_second (o_local_second)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic t_local_stamp to_local_time(input t_utc_stamp u,
                                                   input longint offset_min);
        t_local_stamp r;
        longint y, m, era, yoe, doy, doe, days, secs, z, rem, mp, ly, lm, ld;
        y = longint'(u.year);
        m = longint'(u.month);
        if (m <= 2) begin
            y = y - 1;
        end
        era  = floor_quot(y, 400);
        yoe  = y - era * 400;
        doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + longint'(u.day) - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * DaysPerEra + doe - EpochShiftDays;

        secs = ((days * 24 + longint'(u.hour)) * 60 + longint'(u.minute)) * 60
               + longint'(u.second) + offset_min * 60;
        z    = floor_quot(secs, SecPerDay);
        rem  = secs - z * SecPerDay;

        z   = z + EpochShiftDays;
        era = floor_quot(z, DaysPerEra);
        doe = z - era * DaysPerEra;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        ld  = doy - (153 * mp + 2) / 5 + 1;
        lm  = (mp < 10) ? mp + 3 : mp - 9;
        ly  = yoe + era * 400 + ((lm <= 2) ? 1 : 0);

        r.year   = ly[13:0];
        r.month  = lm[3:0];
        r.day    = ld[4:0];
        r.hour   = 5'(rem / 3600);
        r.minute = 6'((rem % 3600) / 60);
        r.second = 6'(rem % 60);
        return r;
    endfunction

    function automatic t_utc_stamp random_utc();
        t_utc_stamp u;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            u.year   = 14'($urandom_range(1, 9999));
            u.month  = 4'($urandom_range(1, 12));
            u.day    = 5'($urandom_range(1, 31));
            u.hour   = 5'($urandom_range(0, 23));
            u.minute = 6'($urandom_range(0, 59));
            u.second = 6'($urandom_range(0, 59));
        end else if (pick < 75) begin
            u.year   = 14'(year_edges[$urandom_range(0, 11)]);
            u.month  = 4'(month_edges[$urandom_range(0, 5)]);
            u.day    = 5'(day_edges[$urandom_range(0, 5)]);
            u.hour   = 5'(hour_edges[$urandom_range(0, 3)]);
            u.minute = 6'(sixty_edges[$urandom_range(0, 3)]);
            u.second = 6'(sixty_edges[$urandom_range(0, 3)]);
        end else begin
            u.year   = 14'($urandom_range(0, 16383));
            u.month  = 4'($urandom_range(0, 15));
            u.day    = 5'($urandom_range(0, 31));
            u.hour   = 5'($urandom_range(0, 31));
            u.minute = 6'($urandom_range(0, 63));
            u.second = 6'($urandom_range(0, 63));
        end
        return u;
    endfunction

    task automatic queue_utc(input int y, input int mo, input int d, input int h,
                             input int mi, input int s);
        t_utc_stamp u;
        u.year   = 14'(y);
        u.month  = 4'(mo);
        u.day    = 5'(d);
        u.hour   = 5'(h);
        u.minute = 6'(mi);
        u.second = 6'(s);
        pending_utc = {pending_utc, u};
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_utc = {pending_utc, random_utc()};
    endtask

    // Wait until every queued timestamp has transferred and every result is back
    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (pending_utc.size() != 0 || start || expected_local.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_offset(input logic signed [10:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        offset_now = longint'(v);
        n_offsets++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                expected_local = {expected_local, to_local_time(driven_utc, offset_now)};
            end
            if (!(start && busy)) begin
                if (idle_left == 0 && idle_enable && pending_utc.size() != 0
                        && $urandom_range(0, 4) == 0) begin
                    idle_left = $urandom_range(1, 10);
                end
                if (idle_left > 0) begin
                    start <= 1'b0;
                    idle_left--;
                end else if (pending_utc.size() != 0) begin
                    driven_utc = pending_utc.pop_front();
                    i_utc_year   <= driven_utc.year;
                    i_utc_month  <= driven_utc.month;
                    i_utc_day    <= driven_utc.day;
                    i_utc_hour   <= driven_utc.hour;
                    i_utc_minute <= driven_utc.minute;
                    i_utc_second <= driven_utc.second;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_local_stamp got;
        t_local_stamp want;
        if (i_rst_n && o_valid) begin
            got = '{o_local_year, o_local_month, o_local_day,
                    o_local_hour, o_local_minute, o_local_second};
            if (expected_local.size() == 0) begin
                n_fail++;
                if (n_fail <= MaxReports) begin
                    $display("[%0t] result with nothing expected: %0d-%0d-%0d %0d:%0d:%0d",
                             $realtime, got.year, got.month, got.day,
                             got.hour, got.minute, got.second);
                end
            end else begin
                want = expected_local.pop_front();
                n_checked++;
                if (got.year !== want.year || got.month !== want.month
                        || got.day !== want.day || got.hour !== want.hour
                        || got.minute !== want.minute || got.second !== want.second) begin
                    n_fail++;
                    if (n_fail <= MaxReports) begin
                        $display({"[%0t] mismatch: expected %0d-%0d-%0d %0d:%0d:%0d,",
                                  " got %0d-%0d-%0d %0d:%0d:%0d"},
                                 $realtime, want.year, want.month, want.day, want.hour,
                                 want.minute, want.second, got.year, got.month, got.day,
                                 got.hour, got.minute, got.second);
                    end
                end
            end
        end
        if ((start && !busy) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WatchdogLimit) begin
                $display("[%0t] watchdog: no transfer for %0d cycles",
                         $realtime, stall_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        logic signed [10:0] rand_offset;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_utc(1970, 1, 1, 0, 0, 0);
        queue_utc(2000, 2, 29, 12, 34, 56);
        queue_utc(1, 1, 1, 0, 0, 0);
        queue_utc(9999, 12, 31, 23, 59, 59);
        queue_utc(0, 0, 0, 0, 0, 0);
        queue_utc(16383, 15, 31, 31, 63, 63);
        queue_utc(2021, 0, 15, 8, 0, 0);
        queue_utc(2021, 13, 10, 8, 0, 0);
        queue_utc(2021, 14, 10, 8, 0, 0);
        queue_utc(2021, 15, 10, 8, 0, 0);
        queue_utc(2021, 3, 0, 6, 30, 0);
        queue_utc(2021, 12, 31, 24, 0, 0);
        queue_utc(2021, 6, 30, 23, 60, 60);
        queue_utc(1900, 2, 29, 0, 0, 0);
        queue_utc(2100, 3, 1, 0, 0, 0);
        settle();

        // Year wraps below zero and above the 14-bit range
        set_offset(-11'sd1024);
        queue_utc(0, 1, 1, 0, 0, 0);
        queue_utc(2021, 1, 1, 0, 0, 0);
        queue_random(PhaseItems);
        settle();

        set_offset(11'sd1023);
        queue_utc(16383, 12, 31, 23, 59, 59);
        queue_utc(2020, 2, 28, 20, 0, 0);
        queue_random(PhaseItems);
        settle();

        set_offset(-11'sd720);
        queue_random(PhaseItems);
        settle();

        set_offset(11'sd840);
        queue_random(PhaseItems);
        settle();

        repeat (2) begin
            rand_offset = 11'($urandom_range(0, 2047));
            set_offset(rand_offset);
            queue_random(PhaseItems);
            settle();
        end

        set_offset(-11'sd1);
        queue_random(PhaseItems);
        settle();

        idle_enable = 1'b0;
        set_offset(11'sd330);
        queue_random(PhaseItems);
        settle();
        repeat (PipeLatency + 8) @(negedge i_clk);

        $display("Checked %0d conversions under %0d offset settings, extremes -1024 and %s",
                 n_checked, n_offsets, "+1023 min,");
        $display("with edge dates, out-of-range fields and random input idle bursts.");
        if (n_fail == 0 && expected_local.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
